// File: design/rational_arithmetic_unit_defines.svh
// Assertion helpers for the rational arithmetic unit
`ifndef RATIONAL_ARITHMETIC_UNIT_DEFINES_SVH
`define RATIONAL_ARITHMETIC_UNIT_DEFINES_SVH
// assert that an implication holds on every clock outside reset
`define RAU_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// assert with no reset qualifier
`define RAU_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

// File: design/rau_pkg.sv
// ----------------------------------------------------------------------------
// rau_pkg
// Shared opcodes and controller/datapath command and status types.
// ----------------------------------------------------------------------------
`default_nettype none
package rau_pkg;
  typedef enum logic [2:0] {
    CMD_ADD = 3'd0, CMD_SUB = 3'd1, CMD_MUL = 3'd2, CMD_DIV = 3'd3,
    CMD_SET = 3'd4, CMD_CMP = 3'd5, CMD_NEG = 3'd6, CMD_RCP = 3'd7
  } cmd_t;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_ZERO = 2'd1;
  localparam logic [1:0] ST_WIDE = 2'd2;

  typedef struct packed {
    logic load;     // capture operands, start products
    logic prod;     // capture product stage 1 results
    logic comb;     // combine into sign/magnitude pair
    logic gcd_step; // one Euclid subtract-shift step
    logic div_step; // one quotient bit step
    logic pack;     // form final result
  } rau_ctl_t;

  typedef struct packed {
    logic no_reduce;
    logic gcd_done;
    logic div_done;
  } rau_sts_t;
endpackage
`default_nettype wire

// File: design/rau_datapath.sv
// ----------------------------------------------------------------------------
// rau_datapath
// Operand registers, cross products, Euclidean gcd by restoring remainder,
// and bit-serial division by the gcd.
// ----------------------------------------------------------------------------
`default_nettype none
module rau_datapath #(
  parameter int VALUE_WIDTH = 32
) (
  input  wire logic             clk,
  input  wire rau_pkg::rau_ctl_t ctl,
  output rau_pkg::rau_sts_t     sts,
  input  wire logic [2:0]       command,
  input  wire logic [31:0]      a_num,
  input  wire logic [31:0]      a_den,
  input  wire logic [31:0]      b_num,
  input  wire logic [30:0]      b_den,
  output logic [31:0]           result_num,
  output logic [30:0]           result_den,
  output logic [1:0]            order,
  output logic [1:0]            status
);
  import rau_pkg::*;

  localparam logic [63:0] HALF = 64'd1 << (VALUE_WIDTH - 1);

  cmd_t        cmd;
  logic [31:0] an, ad, bn;
  logic [30:0] bd;
  // products: p1, p2 numerator terms, p3 denominator, each sign+mag
  logic [63:0] p1m, p2m, p3m;
  logic        p1s, p2s, p3s;
  logic        neg;
  logic [63:0] nm, dm;
  // Euclid: x, y; remainder computed bit-serially
  logic [63:0] gx, gy, rem;
  logic [6:0]  rcnt;
  logic        in_rem;
  logic [63:0] g;
  // division of nm and dm by g, both in parallel
  logic [63:0] qn, qd, rn, rd;
  logic [6:0]  dcnt;
  logic        cmp_ge, cmp_gt;
  logic        zero_den;

  function automatic logic [31:0] mag32(input logic [31:0] v);
    mag32 = v[31] ? (32'd0 - v) : v;
  endfunction

  logic [31:0] m1a, m1b, m2a, m2b, m3a, m3b;
  logic        s1, s2, s3;

  always_comb begin
    m1a = '0; m1b = '0; m2a = '0; m2b = '0; m3a = '0; m3b = '0;
    s1 = 1'b0; s2 = 1'b0; s3 = 1'b0;
    unique case (cmd)
      CMD_ADD, CMD_SUB, CMD_CMP: begin
        m1a = mag32(an); m1b = {1'b0, bd}; s1 = an[31];
        m2a = mag32(bn); m2b = mag32(ad);  s2 = bn[31] ^ ad[31];
        m3a = mag32(ad); m3b = {1'b0, bd}; s3 = ad[31];
      end
      CMD_MUL: begin
        m1a = mag32(an); m1b = mag32(bn); s1 = an[31] ^ bn[31];
        m3a = mag32(ad); m3b = {1'b0, bd}; s3 = ad[31];
      end
      CMD_DIV: begin
        m1a = mag32(an); m1b = {1'b0, bd}; s1 = an[31];
        m3a = mag32(ad); m3b = mag32(bn);  s3 = ad[31] ^ bn[31];
      end
      CMD_SET: begin
        m1a = mag32(an); m1b = 32'd1; s1 = an[31];
        m3a = mag32(ad); m3b = 32'd1; s3 = ad[31];
      end
      CMD_NEG: begin
        m1a = mag32(an); m1b = 32'd1; s1 = ~an[31];
        m3a = mag32(ad); m3b = 32'd1; s3 = ad[31];
      end
      CMD_RCP: begin
        m1a = mag32(ad); m1b = 32'd1; s1 = ad[31];
        m3a = mag32(an); m3b = 32'd1; s3 = an[31];
      end
      default: ;
    endcase
  end

  assign sts.no_reduce = (cmd == CMD_NEG) || (cmd == CMD_RCP) || (cmd == CMD_CMP);
  assign sts.gcd_done  = ~in_rem && (gy == 64'd0);
  assign sts.div_done  = (dcnt == 7'd64);
  assign g = gx;

  logic [64:0] rsh;
  assign rsh = {rem, gx[~rcnt[5:0]]};

  logic [64:0] nsh, dsh;
  assign nsh = {rn, qn[63]};
  assign dsh = {rd, qd[63]};

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd <= cmd_t'(command);
      an <= a_num; ad <= a_den; bn <= b_num; bd <= b_den;
    end
    if (ctl.prod) begin
      p1m <= {32'd0, m1a} * {32'd0, m1b}; p1s <= s1;
      p2m <= {32'd0, m2a} * {32'd0, m2b}; p2s <= s2;
      p3m <= {32'd0, m3a} * {32'd0, m3b}; p3s <= s3;
      zero_den <= (ad == 32'd0) || (bd == 31'd0);
    end
    if (ctl.comb) begin
      logic        n2s;
      logic        ns;
      logic [63:0] sm;
      n2s = (cmd == CMD_SUB && p2m != 64'd0) ? ~p2s : p2s;
      if (s1 == n2s || cmd == CMD_MUL || cmd == CMD_DIV || cmd == CMD_SET
          || cmd == CMD_NEG || cmd == CMD_RCP) begin
        sm = (cmd == CMD_ADD || cmd == CMD_SUB) ? p1m + p2m : p1m;
        ns = p1s;
      end else if (p1m >= p2m) begin
        sm = p1m - p2m; ns = p1s;
      end else begin
        sm = p2m - p1m; ns = n2s;
      end
      nm <= sm; dm <= p3m; neg <= ns ^ p3s;
      // compare uses signed cross products
      cmp_gt <= (p1s ? -$signed({1'b0, p1m}) : $signed({1'b0, p1m}))
              > (p2s ? -$signed({1'b0, p2m}) : $signed({1'b0, p2m}));
      cmp_ge <= (p1s ? -$signed({1'b0, p1m}) : $signed({1'b0, p1m}))
              >= (p2s ? -$signed({1'b0, p2m}) : $signed({1'b0, p2m}));
      gx <= sm; gy <= p3m; rem <= '0; rcnt <= '0; in_rem <= 1'b0;
      qn <= sm; qd <= p3m; rn <= '0; rd <= '0; dcnt <= '0;
    end
    if (ctl.gcd_step) begin
      if (!in_rem) begin
        in_rem <= 1'b1; rem <= '0; rcnt <= '0;
      end else begin
        logic [64:0] t;
        t = rsh;
        if (t >= {1'b0, gy}) t = t - {1'b0, gy};
        rem <= t[63:0];
        rcnt <= rcnt + 7'd1;
        if (rcnt == 7'd63) begin
          gx <= gy; gy <= t[63:0]; in_rem <= 1'b0;
        end
      end
    end
    if (ctl.div_step) begin
      logic [64:0] tn, td;
      tn = nsh; td = dsh;
      if (tn >= {1'b0, g}) tn = tn - {1'b0, g};
      if (td >= {1'b0, g}) td = td - {1'b0, g};
      rn <= tn[63:0]; rd <= td[63:0];
      qn <= {qn[62:0], nsh >= {1'b0, g}};
      qd <= {qd[62:0], dsh >= {1'b0, g}};
      dcnt <= dcnt + 7'd1;
    end
    if (ctl.pack) begin
      logic [63:0] fn, fd;
      logic        fneg;
      fn = sts.no_reduce ? nm : qn;
      fd = sts.no_reduce ? dm : qd;
      fneg = neg && (fn != 64'd0);
      result_num <= '0; result_den <= '0; order <= '0;
      if (cmd == CMD_CMP) begin
        order <= cmp_gt ? 2'b01 : (cmp_ge ? 2'b00 : 2'b11);
        status <= zero_den ? ST_ZERO : ST_OK;
      end else if (dm == 64'd0) begin
        status <= ST_ZERO;
      end else if (fd > HALF - 64'd1 || (fneg ? fn > HALF : fn > HALF - 64'd1)) begin
        status <= ST_WIDE;
      end else begin
        result_num <= fneg ? (32'd0 - fn[31:0]) : fn[31:0];
        result_den <= fd[30:0];
        status <= ST_OK;
      end
    end
  end
endmodule
`default_nettype wire

// File: design/rau_ctrl.sv
// ----------------------------------------------------------------------------
// rau_ctrl
// Sequencer: load, multiply, combine, gcd loop, divide loop, pack, output.
// ----------------------------------------------------------------------------
`default_nettype none
module rau_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output rau_pkg::rau_ctl_t      ctl,
  input  wire rau_pkg::rau_sts_t sts
);
  import rau_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_PROD, S_COMB, S_GCD, S_DIV, S_PACK, S_OUT} state_t;
  state_t state;

  assign in_ready = (state == S_IDLE);
  assign out_valid = (state == S_OUT);

  always_comb begin
    ctl = '0;
    ctl.load     = (state == S_IDLE) && in_valid;
    ctl.prod     = (state == S_PROD);
    ctl.comb     = (state == S_COMB);
    ctl.gcd_step = (state == S_GCD) && !sts.gcd_done;
    ctl.div_step = (state == S_DIV) && !sts.div_done;
    ctl.pack     = (state == S_PACK);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: if (in_valid) state <= S_PROD;
        S_PROD: state <= S_COMB;
        S_COMB: state <= S_GCD;
        S_GCD: begin
          if (sts.no_reduce) state <= S_PACK;
          else if (sts.gcd_done) state <= S_DIV;
        end
        S_DIV: if (sts.div_done) state <= S_PACK;
        S_PACK: state <= S_OUT;
        S_OUT: if (out_ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// File: design/rational_arithmetic_unit.sv
// ----------------------------------------------------------------------------
// rational_arithmetic_unit
// Fraction ALU with gcd reduction.
// ----------------------------------------------------------------------------
// One item at a time. An item passes through the load, product, combine,
// gcd, pack and output states and waits in output until its result is
// taken. Reducing commands add Euclid remainder steps (each a setup step
// and a bit-serial 64-bit remainder), then bit-serial division by the gcd
// (64 quotient steps and one to finish). Negate, reciprocal and compare
// skip both loops. The next item is taken once the result transfers.
`default_nettype none
`include "rational_arithmetic_unit_defines.svh"
module rational_arithmetic_unit #(
  parameter int VALUE_WIDTH = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  command,
  input  wire logic [31:0] a_num,
  input  wire logic [31:0] a_den,
  input  wire logic [31:0] b_num,
  input  wire logic [30:0] b_den,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      result_num,
  output logic [30:0]      result_den,
  output logic [1:0]       order,
  output logic [1:0]       status
);
  import rau_pkg::*;

  rau_ctl_t ctl;
  rau_sts_t sts;

  rau_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready, .ctl, .sts
  );

  rau_datapath #(.VALUE_WIDTH(VALUE_WIDTH)) u_dp (
    .clk, .ctl, .sts, .command, .a_num, .a_den, .b_num, .b_den,
    .result_num, .result_den, .order, .status
  );

  `RAU_ASSERT(a_no_overlap, !(in_ready && out_valid), "busy and idle at once")
  `RAU_ASSERT(a_pack_then_out, ctl.pack |=> out_valid, "pack not followed by output")
  `RAU_ASSERT(a_status_range, out_valid |-> status != 2'd3, "bad status code")
endmodule
`default_nettype wire

// File: test/rational_arithmetic_unit_tb.sv
// ----------------------------------------------------------------------------
// rational_arithmetic_unit_tb
// Self-checking bench for the fraction ALU: directed corner cases, then
// random fractions of mixed magnitude under several idle/stall patterns,
// with every result checked against a behavioral predictor.
// ----------------------------------------------------------------------------
`default_nettype none
module rational_arithmetic_unit_tb;
  import rau_pkg::*;

  typedef struct packed {
    logic [31:0] num;
    logic [30:0] den;
    logic [1:0]  ord;
    logic [1:0]  status;
  } frac_result_t;

  localparam longint CYCLE_LIMIT = 60000000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  command = '0;
  logic [31:0] a_num = '0;
  logic [31:0] a_den = '0;
  logic [31:0] b_num = '0;
  logic [30:0] b_den = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] result_num;
  logic [30:0] result_den;
  logic [1:0]  order;
  logic [1:0]  status;

  frac_result_t pending_results[$];
  int     error_count = 0;
  int     results_seen = 0;
  int     sent_per_cmd[8];
  int     sender_idle_pct = 0;
  int     receiver_stall_pct = 0;
  int     hold_request = 0;
  int     hold_left = 0;
  longint cycle_count = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  rational_arithmetic_unit i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .command(command), .a_num(a_num), .a_den(a_den),
    .b_num(b_num), .b_den(b_den),
    .out_valid(out_valid), .out_ready(out_ready),
    .result_num(result_num), .result_den(result_den),
    .order(order), .status(status)
  );

  function automatic logic [63:0] magnitude(longint v);
    return (v < 0) ? 64'(-v) : 64'(v);
  endfunction

  // Sign into numerator, optional gcd reduction, range check.
  function automatic frac_result_t pack_fraction(logic nneg, logic [63:0] nm, logic dneg,
                                                 logic [63:0] dm, logic reduce);
    frac_result_t r;
    logic [63:0] x, y, t, half;
    logic neg;
    r = '0;
    half = 64'd1 << 31;
    neg = nneg ^ dneg;
    if (dm == 0) begin
      r.status = ST_ZERO;
      return r;
    end
    if (reduce) begin
      x = nm;
      y = dm;
      while (y != 0) begin
        t = y;
        y = x % y;
        x = t;
      end
      nm = nm / x;
      dm = dm / x;
    end
    if (nm == 0) neg = 1'b0;
    if (dm > half - 1 || (neg ? nm > half : nm > half - 1)) begin
      r.status = ST_WIDE;
      return r;
    end
    r.num = neg ? 32'(-nm) : nm[31:0];
    r.den = dm[30:0];
    r.status = ST_OK;
    return r;
  endfunction

  function automatic frac_result_t predict_fraction(logic [2:0] cmd, logic [31:0] an_r,
                                                    logic [31:0] ad_r, logic [31:0] bn_r,
                                                    logic [30:0] bd_r);
    frac_result_t r;
    longint an, ad, bn, bd, cross_a, cross_b;
    logic [63:0] m1, m2, nm, dm;
    logic s1, s2, ns, ds;
    an = longint'($signed(an_r));
    ad = longint'($signed(ad_r));
    bn = longint'($signed(bn_r));
    bd = longint'(bd_r);
    r = '0;
    case (cmd)
      CMD_ADD, CMD_SUB: begin
        m1 = magnitude(an) * magnitude(bd);
        s1 = (an < 0) != (bd < 0);
        m2 = magnitude(bn) * magnitude(ad);
        s2 = (bn < 0) != (ad < 0);
        if (cmd == CMD_SUB && m2 != 0) s2 = !s2;
        if (s1 == s2) begin
          nm = m1 + m2; ns = s1;
        end else if (m1 >= m2) begin
          nm = m1 - m2; ns = s1;
        end else begin
          nm = m2 - m1; ns = s2;
        end
        dm = magnitude(ad) * magnitude(bd);
        ds = (ad < 0) != (bd < 0);
        r = pack_fraction(ns, nm, ds, dm, 1'b1);
      end
      CMD_MUL: r = pack_fraction((an < 0) != (bn < 0), magnitude(an) * magnitude(bn),
                                 (ad < 0) != (bd < 0), magnitude(ad) * magnitude(bd), 1'b1);
      CMD_DIV: r = pack_fraction((an < 0) != (bd < 0), magnitude(an) * magnitude(bd),
                                 (ad < 0) != (bn < 0), magnitude(ad) * magnitude(bn), 1'b1);
      CMD_SET: r = pack_fraction(an < 0, magnitude(an), ad < 0, magnitude(ad), 1'b1);
      CMD_CMP: begin
        cross_a = an * bd;
        cross_b = bn * ad;
        r.ord = (cross_a < cross_b) ? 2'b11 : (cross_a > cross_b) ? 2'b01 : 2'b00;
        r.status = (ad == 0 || bd == 0) ? ST_ZERO : ST_OK;
      end
      CMD_NEG: r = pack_fraction(!(an < 0), magnitude(an), ad < 0, magnitude(ad), 1'b0);
      default: r = pack_fraction(ad < 0, magnitude(ad), an < 0, magnitude(an), 1'b0);
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Receiver: random stalls, plus a long hold-off on request.
  always @(negedge clk) begin
    if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
    end
  end

  always @(posedge clk) begin
    frac_result_t want;
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $error("result with nothing expected: num=%0d den=%0d", $signed(result_num), result_den);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (result_num !== want.num) begin
          $error("result_num: expected %0d, got %0d", $signed(want.num), $signed(result_num));
          error_count++;
        end
        if (result_den !== want.den) begin
          $error("result_den: expected %0d, got %0d", want.den, result_den);
          error_count++;
        end
        if (order !== want.ord) begin
          $error("order: expected %0d, got %0d", $signed(want.ord), $signed(order));
          error_count++;
        end
        if (status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status);
          error_count++;
        end
      end
    end
  end

  // Called at a falling edge; returns at a falling edge.
  task automatic send_fraction(cmd_t cmd, logic [31:0] an, logic [31:0] ad,
                               logic [31:0] bn, logic [30:0] bd);
    command  <= cmd;
    a_num    <= an;
    a_den    <= ad;
    b_num    <= bn;
    b_den    <= bd;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(predict_fraction(cmd, an, ad, bn, bd));
    sent_per_cmd[cmd]++;
    @(negedge clk);
    if ($urandom_range(0, 99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
  endtask

  task automatic wait_all_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  function automatic logic [31:0] pick_value(int spread);
    case (spread)
      0: return 32'($urandom_range(0, 40)) - 32'd20;
      1: return 32'($signed(16'($urandom)));
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_den(int spread);
    logic [31:0] d;
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 4) return 32'd0;
    case (spread)
      0: d = $urandom_range(1, 20);
      1: d = $urandom_range(1, 65535);
      default: d = $urandom & 32'h7FFF_FFFF;
    endcase
    if (roll < 14) d = -d;
    return d;
  endfunction

  task automatic test_corner_cases();
    send_fraction(CMD_ADD, 32'd1, 32'd2, 32'd1, 31'd3);
    send_fraction(CMD_ADD, 32'h7FFF_FFFF, 32'd1, 32'h7FFF_FFFF, 31'd1);
    send_fraction(CMD_SUB, 32'd3, 32'd4, 32'd3, 31'd4);
    send_fraction(CMD_SUB, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'h7FFF_FFFF);
    send_fraction(CMD_MUL, 32'h8000_0000, 32'd1, 32'h8000_0000, 31'd1);
    send_fraction(CMD_MUL, 32'd0, 32'd7, 32'hFFFF_FFFB, 31'd3);
    send_fraction(CMD_MUL, 32'd6, 32'hFFFF_FFF7, 32'd3, 31'd4);
    send_fraction(CMD_DIV, 32'd5, 32'd2, 32'd0, 31'd3);
    send_fraction(CMD_DIV, 32'hFFFF_FFFE, 32'd3, 32'hFFFF_FFFC, 31'd9);
    send_fraction(CMD_DIV, 32'd1, 32'd0, 32'd1, 31'd0);
    send_fraction(CMD_SET, 32'd0, 32'd0, 32'hFFFF_FFFF, 31'h7FFF_FFFF);
    send_fraction(CMD_SET, 32'd12, 32'hFFFF_FFF8, 32'd0, 31'd0);
    send_fraction(CMD_SET, 32'h8000_0000, 32'hFFFF_FFFF, 32'd0, 31'd0);
    send_fraction(CMD_SET, 32'h8000_0000, 32'h8000_0000, 32'd0, 31'd0);
    send_fraction(CMD_SET, 32'd0, 32'hFFFF_FFF0, 32'd0, 31'd0);
    send_fraction(CMD_CMP, 32'd1, 32'd2, 32'd2, 31'd4);
    send_fraction(CMD_CMP, 32'hFFFF_FFFF, 32'd3, 32'd1, 31'd3);
    send_fraction(CMD_CMP, 32'd5, 32'd0, 32'd1, 31'd2);
    send_fraction(CMD_CMP, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 31'h7FFF_FFFF);
    send_fraction(CMD_NEG, 32'hFFFF_FFFD, 32'd4, 32'd9, 31'd9);
    send_fraction(CMD_NEG, 32'h8000_0000, 32'd1, 32'd0, 31'd0);
    send_fraction(CMD_NEG, 32'd0, 32'hFFFF_FFFF, 32'd0, 31'd0);
    send_fraction(CMD_RCP, 32'd0, 32'd5, 32'd0, 31'd0);
    send_fraction(CMD_RCP, 32'hFFFF_FFF9, 32'd2, 32'd0, 31'd0);
    send_fraction(CMD_RCP, 32'd3, 32'h8000_0000, 32'd0, 31'd0);
    wait_all_results();
  endtask

  task automatic test_random_fractions(int count, int idle_pct, int stall_pct);
    int spread;
    logic [31:0] bd;
    sender_idle_pct = idle_pct;
    receiver_stall_pct = stall_pct;
    repeat (count) begin
      // mostly small operands to keep reductions short, a few full width
      spread = ($urandom_range(0, 99) < 55) ? 0 : ($urandom_range(0, 99) < 60) ? 1 : 2;
      bd = pick_den(spread);
      send_fraction(cmd_t'($urandom_range(0, 7)), pick_value(spread), pick_den(spread),
                    pick_value(spread), bd[30:0]);
    end
    wait_all_results();
  endtask

  // Hold the receiver off while the sender keeps offering transfers.
  task automatic test_output_backpressure();
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    hold_request = 500;
    repeat (8)
      send_fraction(cmd_t'($urandom_range(0, 7)), pick_value(0), pick_den(0),
                    pick_value(0), 31'($urandom_range(1, 20)));
    wait_all_results();
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_corner_cases();
    test_random_fractions(450, 0, 0);
    test_random_fractions(450, 71, 0);
    test_output_backpressure();
    test_random_fractions(450, 0, 71);
    test_random_fractions(450, 12, 12);
    wait_all_results();
    repeat (200) @(posedge clk);
    $display("Covered add %0d, sub %0d, mul %0d, div %0d, set %0d, cmp %0d, neg %0d, rcp %0d",
             sent_per_cmd[0], sent_per_cmd[1], sent_per_cmd[2], sent_per_cmd[3],
             sent_per_cmd[4], sent_per_cmd[5], sent_per_cmd[6], sent_per_cmd[7]);
    $display("%0d results checked, %0d mismatches", results_seen, error_count);
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire

// File: files.f
+incdir+design
design/rau_pkg.sv
design/rau_datapath.sv
design/rau_ctrl.sv
design/rational_arithmetic_unit.sv
test/rational_arithmetic_unit_tb.sv
